/* rtl/aes_pkg.sv */
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box tables and round helper functions.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int ROUNDS = 10;
	localparam int RK_COUNT = ROUNDS + 1;
	localparam int RND_W = $clog2(RK_COUNT + 1);

	localparam logic [7:0] REG_KEY_HIGH = 8'd0;
	localparam logic [7:0] REG_KEY_LOW = 8'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		KX_IDLE,
		KX_RUN
	} kx_state_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		logic [7:0] r;
		r = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		return r;
	endfunction

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] ISBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// state bytes: byte n in bits [127-8n -: 8], column n/4, row n%4
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(4*c + r) -: 8] = SBOX[s[127 - 8*(4*((c + r) % 4) + r) -: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(4*((c + r) % 4) + r) -: 8] = ISBOX[s[127 - 8*(4*c + r) -: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
			xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
	endfunction

	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3, u, v;
		// premultiply form: inverse = forward mix of adjusted column
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		u = xtime(xtime(a0 ^ a2));
		v = xtime(xtime(a1 ^ a3));
		return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
	endfunction

	function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		for (int c = 0; c < 4; c++) begin
			t[127 - 32*c -: 32] = inv ? inv_mix_col(s[127 - 32*c -: 32])
				: mix_col(s[127 - 32*c -: 32]);
		end
		return t;
	endfunction

endpackage

/* rtl/aes_key_expand.sv */
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Expands the key one round key per cycle into a round-key memory.
// ----------------------------------------------------------------------------
module aes_key_expand
	import aes_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [127:0]         key,
	input  logic [RND_W-1:0]     rd_idx,
	output logic [127:0]         rd_key,
	output logic                 busy
);

	kx_state_t         state_q, state_next;
	logic [RND_W-1:0]  cnt_q;
	logic [127:0]      cur_q;
	logic [7:0]        rc_q;
	logic [127:0]      rk_mem [RK_COUNT];
	logic [127:0]      nxt;
	logic [31:0]       t;
	logic              wr_en;
	logic [RND_W-1:0]  wr_idx;
	logic [127:0]      wr_data;
	logic              init_q;
	logic              kick;

	// expand the reset key once reset is released
	assign kick = start || init_q;

	always_comb begin
		t = {SBOX[cur_q[23:16]], SBOX[cur_q[15:8]], SBOX[cur_q[7:0]], SBOX[cur_q[31:24]]}
			^ {rc_q, 24'h0};
		nxt[127:96] = cur_q[127:96] ^ t;
		nxt[95:64]  = cur_q[95:64] ^ nxt[127:96];
		nxt[63:32]  = cur_q[63:32] ^ nxt[95:64];
		nxt[31:0]   = cur_q[31:0] ^ nxt[63:32];
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			KX_IDLE: if (kick) state_next = KX_RUN;
			KX_RUN:  if (cnt_q == RND_W'(ROUNDS) && !kick) state_next = KX_IDLE;
			default: state_next = KX_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q == KX_RUN) || kick;
		wr_en = kick || (state_q == KX_RUN && cnt_q != RND_W'(ROUNDS));
		wr_idx = kick ? '0 : cnt_q + RND_W'(1);
		wr_data = kick ? key : nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KX_IDLE;
			cnt_q <= RND_W'(ROUNDS);
			cur_q <= '0;
			rc_q <= 8'h01;
		end else begin
			state_q <= state_next;
			if (kick) begin
				cnt_q <= '0;
				cur_q <= key;
				rc_q <= 8'h01;
			end else if (state_q == KX_RUN && cnt_q != RND_W'(ROUNDS)) begin
				cnt_q <= cnt_q + RND_W'(1);
				cur_q <= nxt;
				rc_q <= xtime(rc_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) init_q <= 1'b1;
		else init_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (wr_en) rk_mem[wr_idx] <= wr_data;
		rd_key <= rk_mem[rd_idx];
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RND_W'(ROUNDS)) else $error("key counter out of range");
	a_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == KX_IDLE) |-> (cnt_q == RND_W'(ROUNDS)))
		else $error("expansion left early");
	a_start_rst: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (cnt_q == '0 && state_q == KX_RUN)) else $error("restart failed");

endmodule

/* rtl/aes128_block_cipher_unit.sv */
// ----------------------------------------------------------------------------
// AES-128 ECB block cipher
// Encrypts or decrypts 128-bit blocks with one shared round unit.
// ----------------------------------------------------------------------------
// Usage: write the key through cfg_we/cfg_index/cfg_data (index 0 high eight
// bytes, index 1 low eight bytes). Each write re-expands the key, and
// s_axis_tready stays low meanwhile. A request enters on the s_axis
// channel: tuser is the direction (0 encrypt, 1 decrypt), tdata the block
// (block_high in bits 63:0, block_low in 127:64), tlast is passed through.
// One round unit does a full round per cycle. The first round key is read in
// the accepting cycle, so the initial key addition comes first and ten rounds
// follow; the result then shows on m_axis. The next request can be taken in
// the cycle after the output handshake, so no new block enters before the
// last one is through. The round-key memory read latency and the ten-round
// loop set the time a block takes. The result is held until m_axis_tready;
// no new request is taken until it leaves. After reset the key is all zero
// and the round keys for it are built as soon as reset is released.
// ----------------------------------------------------------------------------
module aes128_block_cipher_unit
	import aes_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // block_high, block_low
	input  logic         s_axis_tuser,   // command
	input  logic         s_axis_tlast,   // last_block
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,   // result_high, result_low
	output logic         m_axis_tlast    // last_out
);

	state_t            state_q, state_next;
	logic [63:0]       key_high_q, key_low_q;
	logic              kx_start;
	logic              kx_busy;
	logic [127:0]      rd_key;
	logic [RND_W-1:0]  rd_idx;
	logic [RND_W-1:0]  rnd_q;
	logic              dec_q, last_q, first_q;
	logic [127:0]      st_q;
	logic [127:0]      core, mixed, step;
	logic              final_rnd;
	logic              accept;
	logic [127:0]      key_new;

	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		key_new = {key_high_q, key_low_q};
		kx_start = 1'b0;
		if (cfg_we && cfg_index == REG_KEY_HIGH) begin
			key_new[127:64] = cfg_data;
			kx_start = 1'b1;
		end else if (cfg_we && cfg_index == REG_KEY_LOW) begin
			key_new[63:0] = cfg_data;
			kx_start = 1'b1;
		end
	end

	aes_key_expand u_kx (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (kx_start),
		.key    (key_new),
		.rd_idx (rd_idx),
		.rd_key (rd_key),
		.busy   (kx_busy)
	);

	// rnd_q counts rounds done; key address leads by the read latency
	always_comb begin
		if (state_q == ST_IDLE) rd_idx = s_axis_tuser ? RND_W'(ROUNDS) : '0;
		else if (first_q) rd_idx = dec_q ? RND_W'(ROUNDS - 1) : RND_W'(1);
		else rd_idx = dec_q ? RND_W'(ROUNDS - 2) - rnd_q : rnd_q + RND_W'(2);
	end

	assign final_rnd = (rnd_q == RND_W'(ROUNDS - 1));

	always_comb begin
		core = dec_q ? inv_shift_sub(st_q) : sub_shift(st_q);
		mixed = dec_q ? mix(core ^ rd_key, 1'b1) : (final_rnd ? core : mix(core, 1'b0)) ^ rd_key;
		if (dec_q && final_rnd) mixed = core ^ rd_key;
		step = first_q ? st_q ^ rd_key : mixed;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_next = ST_RUN;
			ST_RUN:  if (!first_q && final_rnd) state_next = ST_DONE;
			ST_DONE: if (m_axis_tready) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE) && !kx_busy;
		m_axis_tvalid = (state_q == ST_DONE);
		m_axis_tdata = {st_q[63:0], st_q[127:64]};
		m_axis_tlast = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_high_q <= '0;
			key_low_q <= '0;
			rnd_q <= '0;
			first_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (kx_start) begin
				key_high_q <= key_new[127:64];
				key_low_q <= key_new[63:0];
			end
			if (accept) begin
				first_q <= 1'b1;
				rnd_q <= '0;
			end else if (state_q == ST_RUN) begin
				if (first_q) first_q <= 1'b0;
				else rnd_q <= rnd_q + RND_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_q <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
			dec_q <= s_axis_tuser;
			last_q <= s_axis_tlast;
		end else if (state_q == ST_RUN) begin
			st_q <= step;
		end
	end

	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		kx_busy |-> !accept) else $error("request taken during expansion");
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> rnd_q <= RND_W'(ROUNDS - 1)) else $error("round overrun");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(st_q)) else $error("result lost");
	a_run_after: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN && first_q)) else $error("round start missed");

endmodule
